// ----- src/report_change_framer_crc16_top_assert.svh -----
// ----------------------------------------------------------------------------
// report_change_framer_crc16_top_assert.svh
// Assertion macros for the report framer; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef REPORT_CHANGE_FRAMER_CRC16_TOP_ASSERT_SVH
`define REPORT_CHANGE_FRAMER_CRC16_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcf: same-cycle check failed");

// next-cycle implication
`define RCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcf: next-cycle check failed");

`else

`define RCF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/rcf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcf_pkg
// Constants, types and the CRC-16 byte step shared by the report framer.
// ----------------------------------------------------------------------------
package rcf_pkg;

    localparam int REPORT_BYTES = 8;
    localparam int REPORT_W     = 64;
    localparam logic [REPORT_W-1:0] REPORT_MASK =
        {REPORT_W{1'b1}} >> (REPORT_W - 8 * REPORT_BYTES);

    localparam int FRAME_LEN = 16;
    localparam int CRC_SPAN  = 14;
    localparam int HEAD_W    = 8 * CRC_SPAN;
    localparam int POS_W     = $clog2(FRAME_LEN);

    localparam logic [7:0]  FRAME_MAGIC   = 8'hB8;
    localparam logic [7:0]  FRAME_TYPE    = 8'h31;
    localparam logic [7:0]  FRAME_VERSION = 8'h01;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] PERIOD_RESET  = 16'd100;

    // frame head handed to the serializer; byte 0 in bits 7:0
    typedef struct packed {
        logic              load;
        logic [HEAD_W-1:0] head;
    } t_frame_load;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- src/rcf_ifs.sv -----
// ----------------------------------------------------------------------------
// rcf_ifs
// Valid/ready channels of the report framer: report in, frame out, config.
// ----------------------------------------------------------------------------
interface rcf_in_if;
    logic                         valid;
    logic                         ready;
    logic [rcf_pkg::REPORT_W-1:0] report_bytes;
    logic                         key_active;
    logic [7:0]                   lead_key;
    logic                         stats_present;
    logic                         scan_has_seq;
    logic                         scan_any_error;

    modport source (output valid, report_bytes, key_active, lead_key, stats_present,
                    scan_has_seq, scan_any_error, input ready);
    modport sink   (input valid, report_bytes, key_active, lead_key, stats_present,
                    scan_has_seq, scan_any_error, output ready);
endinterface

interface rcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface rcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] refresh_period;

    modport source (output valid, refresh_period, input ready);
    modport sink   (input valid, refresh_period, output ready);
endinterface

// ----- src/rcf_serializer.sv -----
// ----------------------------------------------------------------------------
// rcf_serializer
// Sends a 14-byte frame head one byte per cycle while the receiver is ready,
// folding each byte into the running CRC, then appends the CRC low and high bytes.
// ----------------------------------------------------------------------------
module rcf_serializer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rcf_pkg::t_frame_load i_load,
    output logic                 o_can_load,
    rcf_out_if.source            o_frame
);

    localparam logic [rcf_pkg::POS_W-1:0] CRC_LO_POS = rcf_pkg::POS_W'(rcf_pkg::CRC_SPAN);
    localparam logic [rcf_pkg::POS_W-1:0] CRC_HI_POS = rcf_pkg::POS_W'(rcf_pkg::CRC_SPAN + 1);
    localparam logic [rcf_pkg::POS_W-1:0] LAST_POS   = rcf_pkg::POS_W'(rcf_pkg::FRAME_LEN - 1);
    localparam logic [rcf_pkg::POS_W-1:0] POS_STEP   = rcf_pkg::POS_W'(1);

    logic                        r_busy, n_busy;
    logic [rcf_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [rcf_pkg::HEAD_W-1:0]  r_shift, n_shift;
    logic [15:0]                 r_crc, n_crc;
    logic                        out_fire;

    assign out_fire   = r_busy && o_frame.ready;
    assign o_can_load = !r_busy || (out_fire && (r_pos == LAST_POS));

    assign o_frame.valid      = r_busy;
    assign o_frame.frame_last = (r_pos == LAST_POS);

    always_comb begin
        case (r_pos)
            CRC_LO_POS: o_frame.frame_byte = r_crc[7:0];
            CRC_HI_POS: o_frame.frame_byte = r_crc[15:8];
            default:    o_frame.frame_byte = r_shift[7:0];
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_pos   = r_pos;
        n_shift = r_shift;
        n_crc   = r_crc;
        if (i_load.load && o_can_load) begin
            n_busy  = 1'b1;
            n_pos   = '0;
            n_shift = i_load.head;
            n_crc   = rcf_pkg::CRC_INIT;
        end else if (out_fire) begin
            n_pos = r_pos + POS_STEP;
            if (r_pos < CRC_LO_POS) begin
                n_shift = r_shift >> 8;
                n_crc   = rcf_pkg::crc16_byte(r_crc, r_shift[7:0]);
            end
            if (r_pos == LAST_POS) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_crc   <= n_crc;
    end

endmodule

// ----- src/report_change_framer_crc16_top.sv -----
// ----------------------------------------------------------------------------
// report_change_framer_crc16_top
// Keyboard report framer with change detection, periodic refresh and a
// CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Usage:
//   i_item  : one polled report with its flags per item (valid/ready).
//   o_frame : 16 items per emitted frame, one byte each, frame_last on the
//             CRC high byte.
//   i_cfg   : writes refresh_period; always ready. Write only while idle.
// An accepted report is registered in the input register, where the send
// decision is made; if a frame is due, its head is loaded into the serializer
// once that can take it, and its first byte then appears on o_frame.
// Reports that send nothing are taken one per cycle. A frame occupies the byte
// serializer until all 16 bytes are sent, so a report that sends a frame waits
// in the input register while the serializer is busy; frames follow each other with no gap.
// When the receiver stalls, the current byte holds, the serializer holds,
// and a report waiting on a frame holds in the input register, so i_item
// ready drops. Reset clears the sequence number and refresh phase, sets the
// last sent report to all ones and the period to 100; no frame is pending.
// ----------------------------------------------------------------------------
`include "report_change_framer_crc16_top_assert.svh"

module report_change_framer_crc16_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcf_in_if.sink     i_item,
    rcf_cfg_if.sink    i_cfg,
    rcf_out_if.source  o_frame
);

    // input register
    logic                         r_in_valid;
    logic [rcf_pkg::REPORT_W-1:0] r_rep;
    logic                         r_down;
    logic [7:0]                   r_fkey;
    logic                         r_stats;
    logic                         r_hseq;
    logic                         r_anyerr;

    // block state
    logic [15:0]                  r_period;
    logic [15:0]                  r_phase, n_phase;
    logic [7:0]                   r_seq;
    logic [rcf_pkg::REPORT_W-1:0] r_last;

    logic                         in_fire;
    logic                         changed;
    logic                         refresh;
    logic                         need_frame;
    logic                         consume;
    logic                         can_load;
    logic [rcf_pkg::REPORT_W-1:0] rep_m;
    logic [7:0]                   flags;
    logic [7:0]                   seq_next;
    logic [16:0]                  phase_inc;
    rcf_pkg::t_frame_load         load;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_in_valid || consume;
    assign in_fire      = i_item.valid && i_item.ready;

    assign rep_m      = r_rep & rcf_pkg::REPORT_MASK;
    assign changed    = rep_m != (r_last & rcf_pkg::REPORT_MASK);
    assign refresh    = (r_period != 16'd0) && (r_phase == 16'd0);
    assign need_frame = changed || refresh;
    assign consume    = r_in_valid && (!need_frame || can_load);
    assign seq_next   = r_seq + 8'd1;
    assign phase_inc  = {1'b0, r_phase} + 17'd1;

    assign flags = {!r_stats, 4'b0000, r_stats && r_anyerr, r_stats && r_hseq, r_down};

    always_comb begin
        if (r_period == 16'd0) begin
            n_phase = 16'd0;
        end else if (phase_inc >= {1'b0, r_period}) begin
            n_phase = 16'd0;
        end else begin
            n_phase = phase_inc[15:0];
        end
    end

    assign load.load = r_in_valid && need_frame;
    assign load.head = {r_fkey, rep_m, flags, seq_next,
                        rcf_pkg::FRAME_VERSION, rcf_pkg::FRAME_TYPE, rcf_pkg::FRAME_MAGIC};

    rcf_serializer u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .o_can_load (can_load),
        .o_frame    (o_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_period   <= rcf_pkg::PERIOD_RESET;
            r_phase    <= 16'd0;
            r_seq      <= 8'd0;
            r_last     <= '1;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_period <= i_cfg.refresh_period;
            end
            if (consume) begin
                r_phase <= n_phase;
                if (need_frame) begin
                    r_seq  <= seq_next;
                    r_last <= rep_m;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rep    <= i_item.report_bytes;
            r_down   <= i_item.key_active;
            r_fkey   <= i_item.lead_key;
            r_stats  <= i_item.stats_present;
            r_hseq   <= i_item.scan_has_seq;
            r_anyerr <= i_item.scan_any_error;
        end
    end

    // a sent report becomes the comparison base
    `RCF_ASSERT_NEXT(a_last_follows_send, i_clk, i_rst_n, consume && need_frame, r_last == $past(rep_m))
    // sequence moves only with a frame
    `RCF_ASSERT_NEXT(a_seq_only_on_send, i_clk, i_rst_n, !(consume && need_frame), r_seq == $past(r_seq))
    // disabled refresh keeps the phase at zero
    `RCF_ASSERT_NEXT(a_phase_idle, i_clk, i_rst_n, consume && (r_period == 16'd0), r_phase == 16'd0)
    // a frame is only started when the serializer can take it
    `RCF_ASSERT_NOW(a_load_gated, i_clk, i_rst_n, consume && need_frame, can_load)

endmodule

// ----- tb/rcf_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcf_frame_checker
// Watches the report, config and frame channels of the report framer. It
// predicts the 16 frame bytes due for each accepted report that sends a frame
// and compares every accepted frame byte against the oldest byte still due.
// ----------------------------------------------------------------------------
module rcf_frame_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rcf_in_if    i_item,
    rcf_cfg_if   i_cfg,
    rcf_out_if   i_frame,
    output int   o_pending,
    output int   o_fail_count
);
    import rcf_pkg::*;

    localparam logic [7:0] FLAG_DOWN     = 8'h01;
    localparam logic [7:0] FLAG_HAS_SEQ  = 8'h02;
    localparam logic [7:0] FLAG_SCAN_ERR = 8'h04;
    localparam logic [7:0] FLAG_NO_STATS = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic [15:0]         period;
    logic [15:0]         phase;
    logic [7:0]          seq_num;
    logic [REPORT_W-1:0] last_sent;
    t_frame_byte         frame_bytes_due[$];
    int                  mismatches;

    // CRC-16/CCITT-FALSE over the 14 head bytes, one bit at a time
    function automatic logic [15:0] ccitt_crc14(input logic [HEAD_W-1:0] head);
        logic [15:0] c;
        logic        fb;
        c = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) begin
            for (int b = 7; b >= 0; b--) begin
                fb = c[15] ^ head[8*i + b];
                c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_frame_byte         got;
        t_frame_byte         want;
        logic [REPORT_W-1:0] rep;
        logic [7:0]          flags;
        logic [HEAD_W-1:0]   head;
        logic [15:0]         crc;
        logic                changed;
        logic                refresh;
        if (!i_rst_n) begin
            period     = PERIOD_RESET;
            phase      = '0;
            seq_num    = '0;
            last_sent  = '1;
            mismatches = 0;
            frame_bytes_due.delete();
        end else begin
            if (i_frame.valid && i_frame.ready) begin
                got = '{data: i_frame.frame_byte, last: i_frame.frame_last};
                if (frame_bytes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected frame byte: expected none, actual %h last %b",
                             $time, got.data, got.last);
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (got.data !== want.data) begin
                        mismatches++;
                        $display("%0t: frame_byte mismatch: expected %h, actual %h",
                                 $time, want.data, got.data);
                    end
                    if (got.last !== want.last) begin
                        mismatches++;
                        $display("%0t: frame_last mismatch: expected %b, actual %b",
                                 $time, want.last, got.last);
                    end
                end
            end

            if (i_cfg.valid && i_cfg.ready)
                period = i_cfg.refresh_period;

            if (i_item.valid && i_item.ready) begin
                rep     = i_item.report_bytes & REPORT_MASK;
                changed = rep != (last_sent & REPORT_MASK);
                refresh = (period != 16'd0) && (phase == 16'd0);
                // phase wraps to zero also when the period was lowered below it
                if (period == 16'd0 || ({1'b0, phase} + 17'd1 >= {1'b0, period}))
                    phase = '0;
                else
                    phase = phase + 16'd1;

                if (changed || refresh) begin
                    seq_num = seq_num + 8'd1;
                    flags   = i_item.key_active ? FLAG_DOWN : 8'h00;
                    if (i_item.stats_present) begin
                        if (i_item.scan_has_seq)
                            flags = flags | FLAG_HAS_SEQ;
                        if (i_item.scan_any_error)
                            flags = flags | FLAG_SCAN_ERR;
                    end else begin
                        flags = flags | FLAG_NO_STATS;
                    end
                    head = {i_item.lead_key, rep, flags, seq_num,
                            FRAME_VERSION, FRAME_TYPE, FRAME_MAGIC};
                    crc  = ccitt_crc14(head);
                    for (int i = 0; i < CRC_SPAN; i++)
                        frame_bytes_due.push_back('{data: head[8*i +: 8], last: 1'b0});
                    frame_bytes_due.push_back('{data: crc[7:0], last: 1'b0});
                    frame_bytes_due.push_back('{data: crc[15:8], last: 1'b1});
                    last_sent = rep;
                end
            end
        end
        o_pending    <= frame_bytes_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/tb_report_change_framer_crc16_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_report_change_framer_crc16_top
// Drives polled keyboard reports and refresh period writes into the framer,
// with random idle bursts on both channels, a long receiver hold-off and
// full drains between periods. Frame bytes are checked by rcf_frame_checker.
// ----------------------------------------------------------------------------
module tb_report_change_framer_crc16_top;
    import rcf_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 82;

    typedef struct packed {
        logic [REPORT_W-1:0] report;
        logic                down;
        logic [7:0]          key;
        logic                stats;
        logic                has_seq;
        logic                any_err;
    } t_poll;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   src_idle_on = 1'b1;
    bit   snk_idle_on = 1'b1;
    bit   hold_req    = 1'b0;
    int   cycles      = 0;
    int   pending;
    int   fail_count;

    rcf_in_if  item_if ();
    rcf_cfg_if cfg_if ();
    rcf_out_if frame_if ();

    report_change_framer_crc16_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .i_cfg   (cfg_if),
        .o_frame (frame_if)
    );

    rcf_frame_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_if),
        .i_cfg        (cfg_if),
        .i_frame      (frame_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_report_change_framer_crc16_top NOT OK");
            $finish;
        end
    end

    // frame receiver: random stalls, plus one long hold-off on request
    initial begin : frame_sink
        frame_if.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                frame_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                frame_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                frame_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic offer_poll(input t_poll p);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item_if.valid          <= 1'b1;
        item_if.report_bytes   <= p.report;
        item_if.key_active     <= p.down;
        item_if.lead_key       <= p.key;
        item_if.stats_present  <= p.stats;
        item_if.scan_has_seq   <= p.has_seq;
        item_if.scan_any_error <= p.any_err;
        do @(posedge clk); while (!item_if.ready);
    endtask

    // wait until every due frame byte is out and the input register is empty
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(input logic [15:0] value);
        drain();
        cfg_if.valid          <= 1'b1;
        cfg_if.refresh_period <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_poll               p;
        t_poll               keep;
        logic [REPORT_W-1:0] prev_rep;
        int                  sel;

        item_if.valid          <= 1'b0;
        item_if.report_bytes   <= '0;
        item_if.key_active     <= 1'b0;
        item_if.lead_key       <= '0;
        item_if.stats_present  <= 1'b0;
        item_if.scan_has_seq   <= 1'b0;
        item_if.scan_any_error <= 1'b0;
        cfg_if.valid           <= 1'b0;
        cfg_if.refresh_period  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // all-ones report matches the reset value: only the refresh sends it
        p = '{'1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1};
        repeat (2) offer_poll(p);
        offer_poll('{64'h0, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b1});
        offer_poll('{64'h8000_0000_0000_0001, 1'b0, 8'h80, 1'b1, 1'b1, 1'b0});
        offer_poll('{64'hFEDC_BA98_7654_3210, 1'b0, 8'h01, 1'b1, 1'b0, 1'b1});
        keep = '{64'h0123_4567_89AB_CDEF, 1'b1, 8'h5A, 1'b1, 1'b0, 1'b0};
        repeat (2) offer_poll(keep);

        // period lowered below the phase, then refresh on every poll
        write_period(16'd1);
        repeat (3) offer_poll(keep);

        // refresh off: only changes send
        write_period(16'd0);
        repeat (2) offer_poll(keep);
        keep = '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
        offer_poll(keep);

        write_period(16'hFFFF);
        repeat (2) offer_poll(keep);

        write_period(16'd2);
        repeat (3) offer_poll(keep);
        prev_rep = keep.report;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       write_period(16'($urandom_range(1, 20)));
                1:       write_period(16'd0);
                2:       write_period(16'hFFFF);
                3:       write_period(16'($urandom));
                default: write_period(16'd3);
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                src_idle_on = (ph != RANDOM_PHASES - 1) && ((k / 30) % 2 == 0);
                snk_idle_on = (ph != RANDOM_PHASES - 1) && ((k / 25) % 2 == 0);
                if (ph == 0 && k == 20)
                    hold_req = 1'b1;
                if (ph == 2 && k == 50)
                    drain();
                sel = $urandom_range(0, 9);
                if (sel < 3)
                    p.report = prev_rep;
                else if (sel < 5)
                    p.report = prev_rep ^ (64'd1 << $urandom_range(0, REPORT_W - 1));
                else
                    p.report = {$urandom, $urandom};
                p.down    = 1'($urandom);
                p.key     = 8'($urandom);
                p.stats   = 1'($urandom);
                p.has_seq = 1'($urandom);
                p.any_err = 1'($urandom);
                offer_poll(p);
                prev_rep = p.report;
            end
        end

        drain();
        if (fail_count == 0)
            $display("tb_report_change_framer_crc16_top OK");
        else
            $display("tb_report_change_framer_crc16_top NOT OK");
        $finish;
    end

endmodule
